[rtl/assert_macros.svh]
// Assertion macros shared by the impact detector queue and back part.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define AID_ASSERT_IMP(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("impact detector assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define AID_ASSERT_NXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("impact detector assertion failed");

`endif

[rtl/aid_pkg.sv]
// Types and constants shared by the accelerometer impact detector.
`timescale 1ns / 1ps

package aid_pkg;

    // Input word: one three-axis sample with its timestamp.
    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic [31:0]        time_ms;
    } in_word_t;

    // Result word: magnitude in counts and the impact flag.
    typedef struct packed {
        logic [15:0] magnitude;
        logic        impact;
    } out_word_t;

    // Word held in the queue between the front and back parts.
    typedef struct packed {
        logic [31:0] sum_sq;
        logic [31:0] time_ms;
    } q_word_t;

    // Configuration register set.
    typedef struct packed {
        logic [15:0] impact_threshold;
        logic [15:0] tap_ceiling;
        logic [15:0] spike_delta;
        logic [15:0] debounce_ms;
    } cfg_t;

    // Register indexes of the configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMPACT_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAP_CEILING      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPIKE_DELTA      = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_MS      = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [15:0] RST_IMPACT_THRESHOLD = 16'd10240;
    localparam logic [15:0] RST_TAP_CEILING      = 16'd22528;
    localparam logic [15:0] RST_SPIKE_DELTA      = 16'd737;
    localparam logic [15:0] RST_DEBOUNCE_MS      = 16'd130;

    // Square root: one result bit per step, from two bits of the 32-bit radicand.
    localparam int          ROOT_STEPS     = 16;
    localparam int          STEP_W         = $clog2(ROOT_STEPS);
    localparam logic [31:0] ROOT_FIRST_BIT = 32'h4000_0000;

endpackage

[rtl/accel_impact_detector.sv]
// Top level of the accelerometer impact detector.
`timescale 1ns / 1ps

// Accelerometer impact detector.
// Input channel in_valid/in_ready carries one word: three signed axis
// samples in counts (4096 per g) and a millisecond timestamp. Output channel
// out_valid/out_ready returns one word per sample: the floored magnitude in
// counts and an impact flag. Thresholds are set through cfg_we, cfg_index and
// cfg_data, one register per write, taken at once; write them only while the
// block is idle.
// A result passes, after input acceptance, through the second front stage,
// the queue write, the back part taking the word, the shared root iteration
// and the decision step. The back part takes a new word only once its
// result has been loaded, so that root iteration sets the sample rate.
// Reset clears the queue, the previous magnitude and the last impact time and
// loads the default thresholds. When the receiver stalls the result is held;
// the back part waits in its decision step and the queue and front stages go
// on accepting samples until they fill.

module accel_impact_detector
    import aid_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_word_t               in_word,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_word_t              out_word,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_data
);

    cfg_t    cfg_reg;
    logic    push_valid;
    logic    push_ready;
    q_word_t push_word;
    logic    pop_valid;
    logic    pop_ready;
    q_word_t pop_word;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.impact_threshold <= RST_IMPACT_THRESHOLD;
            cfg_reg.tap_ceiling      <= RST_TAP_CEILING;
            cfg_reg.spike_delta      <= RST_SPIKE_DELTA;
            cfg_reg.debounce_ms      <= RST_DEBOUNCE_MS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IMPACT_THRESHOLD: cfg_reg.impact_threshold <= cfg_data;
                CFG_TAP_CEILING:      cfg_reg.tap_ceiling      <= cfg_data;
                CFG_SPIKE_DELTA:      cfg_reg.spike_delta      <= cfg_data;
                CFG_DEBOUNCE_MS:      cfg_reg.debounce_ms      <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Sample intake and sum of squares.
    aid_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_word    (in_word),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word)
    );

    // Queue between the two parts.
    aid_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_word   (pop_word)
    );

    // Square root, decision and result register.
    aid_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_word  (pop_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

endmodule

[rtl/aid_front.sv]
// Front part: takes samples and forms the sum of squares of the three axes.
`timescale 1ns / 1ps

module aid_front
    import aid_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_word_t in_word,
    output logic     push_valid,
    input  logic     push_ready,
    output q_word_t  push_word
);

    logic        s1_valid_reg;
    logic [15:0] abs_x_reg;
    logic [15:0] abs_y_reg;
    logic [15:0] abs_z_reg;
    logic [31:0] s1_time_reg;

    logic        s2_valid_reg;
    logic [31:0] sq_x_reg;
    logic [31:0] sq_y_reg;
    logic [31:0] sq_z_reg;
    logic [31:0] s2_time_reg;

    logic        s2_free;
    logic [15:0] abs_x_next;
    logic [15:0] abs_y_next;
    logic [15:0] abs_z_next;

    // Magnitude of each axis; the most negative count maps to 32768.
    assign abs_x_next = in_word.accel_x[15] ? (~in_word.accel_x + 16'd1) : in_word.accel_x;
    assign abs_y_next = in_word.accel_y[15] ? (~in_word.accel_y + 16'd1) : in_word.accel_y;
    assign abs_z_next = in_word.accel_z[15] ? (~in_word.accel_z + 16'd1) : in_word.accel_z;

    // The second stage moves on when it is empty or the queue takes its word.
    assign s2_free  = !s2_valid_reg || push_ready;
    assign in_ready = !s1_valid_reg || s2_free;

    // Stage one control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // Stage one payload: absolute values and timestamp.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            abs_x_reg   <= abs_x_next;
            abs_y_reg   <= abs_y_next;
            abs_z_reg   <= abs_z_next;
            s1_time_reg <= in_word.time_ms;
        end
    end

    // Stage two control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_free)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Stage two payload: the three squares, each below 2^30 plus one.
    always_ff @(posedge clk)
    begin
        if (s2_free && s1_valid_reg)
        begin
            sq_x_reg    <= 32'(abs_x_reg * abs_x_reg);
            sq_y_reg    <= 32'(abs_y_reg * abs_y_reg);
            sq_z_reg    <= 32'(abs_z_reg * abs_z_reg);
            s2_time_reg <= s1_time_reg;
        end
    end

    // The sum stays below 3 * 2^30 + 3, so 32 bits hold it.
    assign push_valid        = s2_valid_reg;
    assign push_word.sum_sq  = sq_x_reg + sq_y_reg + sq_z_reg;
    assign push_word.time_ms = s2_time_reg;

endmodule

[rtl/aid_queue.sv]
// Short queue that decouples the front part from the back part.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module aid_queue
    import aid_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_valid,
    output logic    push_ready,
    input  q_word_t push_word,
    output logic    pop_valid,
    input  logic    pop_ready,
    output q_word_t pop_word
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    q_word_t           entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_word   = entry_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // The count never passes the depth, and an empty or full queue has its
    // pointers together.
    `AID_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH))
    `AID_ASSERT_IMP(a_ptr_meet, (count_reg == '0) || (count_reg == CNT_W'(DEPTH)), wr_ptr_reg == rd_ptr_reg)

endmodule

[rtl/aid_back.sv]
// Back part: iterative square root, impact decision and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module aid_back
    import aid_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  q_word_t   pop_word,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_ROOT = 3'b010,
        ST_DONE = 3'b100
    } back_state_t;

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [31:0]       rem_reg;
    logic [31:0]       root_reg;
    logic [31:0]       bit_reg;
    logic [STEP_W-1:0] step_reg;
    logic [31:0]       time_reg;
    logic [15:0]       prev_mag_reg;
    logic [31:0]       last_impact_reg;
    logic              out_valid_reg;
    out_word_t         out_word_reg;

    logic [31:0]       trial;
    logic              take;
    logic [15:0]       mag;
    logic [16:0]       rise;
    logic [31:0]       elapsed;
    logic              hit;
    logic              load;

    assign pop_ready = (state_reg == ST_IDLE);

    // One step of the digit-by-digit root: try to subtract root + bit.
    assign trial = root_reg + bit_reg;
    assign take  = (rem_reg >= trial);

    // Impact decision on the finished root.
    assign mag     = root_reg[15:0];
    assign rise    = {1'b0, mag} - {1'b0, prev_mag_reg};
    assign elapsed = time_reg - last_impact_reg;
    assign hit     = (mag > cfg.impact_threshold) && (mag < cfg.tap_ceiling)
                  && ($signed(rise) > $signed({1'b0, cfg.spike_delta}))
                  && (elapsed > {16'd0, cfg.debounce_ms});

    // The result register is loaded once it is free or being emptied.
    assign load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (step_reg == STEP_W'(ROOT_STEPS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and the detector's history.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            step_reg        <= '0;
            prev_mag_reg    <= '0;
            last_impact_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE)
            begin
                step_reg <= '0;
            end
            else if (state_reg == ST_ROOT)
            begin
                step_reg <= step_reg + 1'b1;
            end
            if (load)
            begin
                prev_mag_reg <= mag;
                if (hit)
                begin
                    last_impact_reg <= time_reg;
                end
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Root datapath and result payload.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && pop_valid)
        begin
            rem_reg  <= pop_word.sum_sq;
            root_reg <= '0;
            bit_reg  <= ROOT_FIRST_BIT;
            time_reg <= pop_word.time_ms;
        end
        else if (state_reg == ST_ROOT)
        begin
            if (take)
            begin
                rem_reg  <= rem_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (load)
        begin
            out_word_reg.magnitude <= mag;
            out_word_reg.impact    <= hit;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // The finished root fits the magnitude field, a flagged result lies above
    // the threshold, and a hit records its timestamp.
    `AID_ASSERT_IMP(a_root_fits, state_reg == ST_DONE, root_reg[31:16] == 16'd0)
    `AID_ASSERT_IMP(a_hit_above, out_valid_reg && out_word_reg.impact, out_word_reg.magnitude > cfg.impact_threshold)
    `AID_ASSERT_NXT(a_hit_time, load && hit, last_impact_reg == $past(time_reg))

endmodule
